// ===== rtl/lpcr_pkg.sv =====
// ----------------------------------------------------------------------------
// Load PI current regulator package
// Shared types, register indexes and arithmetic constants of the regulator.
// ----------------------------------------------------------------------------
`default_nettype none

package lpcr_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int GAIN_SHIFT  = 8;
    localparam int GAIN_DIVISOR = 1 << GAIN_SHIFT;

    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 16;

    localparam logic [CFG_ADDR_BITS-1:0] REG_TARGET_LEVEL = 3'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_PROP_GAIN    = 3'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_INT_GAIN     = 3'd2;
    localparam logic [CFG_ADDR_BITS-1:0] REG_DUTY_LIMIT   = 3'd3;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ACCUM_UPPER  = 3'd4;
    localparam logic [CFG_ADDR_BITS-1:0] REG_ACCUM_LOWER  = 3'd5;
    localparam logic [CFG_ADDR_BITS-1:0] REG_OPEN_LEVEL   = 3'd6;
    localparam logic [CFG_ADDR_BITS-1:0] REG_SHORT_LEVEL  = 3'd7;

    localparam logic [1:0] COND_OPEN       = 2'd0;
    localparam logic [1:0] COND_REGULATING = 2'd1;
    localparam logic [1:0] COND_SHORT      = 2'd2;
    localparam logic [1:0] COND_DISCONNECT = 2'd3;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] target_level;
        logic [15:0]            prop_gain;
        logic [15:0]            int_gain;
        logic [15:0]            duty_limit;
        logic signed [15:0]     accum_upper;
        logic signed [15:0]     accum_lower;
        logic [SAMPLE_BITS-1:0] open_level;
        logic [SAMPLE_BITS-1:0] short_level;
    } lpcr_cfg_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] sample;
        logic                   load_enable;
        logic                   fault;
        logic                   clear_sticky;
    } lpcr_item_t;

    typedef struct packed {
        logic [15:0] duty;
        logic        pwm_on;
        logic        switch_on;
        logic        standby;
        logic [1:0]  load_condition;
        logic        latched_fault;
        logic        clamped;
    } lpcr_result_t;

endpackage

`default_nettype wire

// ===== rtl/lpcr_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// Load PI current regulator configuration registers
// Holds the eight control registers, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcr_cfg_regs (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [lpcr_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [lpcr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    output lpcr_pkg::lpcr_cfg_t                      cfg
);
    import lpcr_pkg::*;

    lpcr_cfg_t cfg_reg;
    lpcr_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                REG_TARGET_LEVEL: cfg_next.target_level = cfg_wdata[SAMPLE_BITS-1:0];
                REG_PROP_GAIN:    cfg_next.prop_gain    = cfg_wdata;
                REG_INT_GAIN:     cfg_next.int_gain     = cfg_wdata;
                REG_DUTY_LIMIT:   cfg_next.duty_limit   = cfg_wdata;
                REG_ACCUM_UPPER:  cfg_next.accum_upper  = $signed(cfg_wdata);
                REG_ACCUM_LOWER:  cfg_next.accum_lower  = $signed(cfg_wdata);
                REG_OPEN_LEVEL:   cfg_next.open_level   = cfg_wdata[SAMPLE_BITS-1:0];
                REG_SHORT_LEVEL:  cfg_next.short_level  = cfg_wdata[SAMPLE_BITS-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.target_level <= '0;
            cfg_reg.prop_gain    <= 16'd1;
            cfg_reg.int_gain     <= 16'd1;
            cfg_reg.duty_limit   <= 16'hFFFF;
            cfg_reg.accum_upper  <= 16'sh7FFF;
            cfg_reg.accum_lower  <= 16'sh8000;
            cfg_reg.open_level   <= '0;
            cfg_reg.short_level  <= '1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== rtl/lpcr_core.sv =====
// ----------------------------------------------------------------------------
// Load PI current regulator core
// Load classification, PI law with conditional integration and the
// controller state, updated once for every item that moves to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module lpcr_core (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire lpcr_pkg::lpcr_item_t item,
    input  wire lpcr_pkg::lpcr_cfg_t  cfg,
    output lpcr_pkg::lpcr_result_t    result
);
    import lpcr_pkg::*;

    logic signed [17:0] acc_reg, acc_next;
    logic               sat_reg, sat_next;
    logic [15:0]        held_reg, held_next;
    logic [15:0]        duty_reg, duty_next;
    logic               sticky_reg, sticky_next;

    logic               sticky_eff;
    logic               disconnect;
    logic               is_open;
    logic               is_short;
    logic signed [SAMPLE_BITS:0] err;
    logic               big_err;
    logic               integrate;
    logic signed [17:0] acc_int;
    logic signed [27:0] prod_p;
    logic signed [34:0] prod_i;
    logic signed [35:0] sum;
    logic signed [35:0] sum_adj;
    logic signed [35:0] quot;
    logic               over;
    logic [15:0]        pi_out;

    always_comb begin
        sticky_eff = sticky_reg & ~item.clear_sticky;
        disconnect = !item.load_enable || item.fault || sticky_eff;
        is_open    = item.sample <= cfg.open_level;
        is_short   = !is_open && (item.sample >= cfg.short_level);

        err     = $signed({1'b0, cfg.target_level}) - $signed({1'b0, item.sample});
        big_err = (err > 11'sd1) || (err < -11'sd1);

        integrate = !sat_reg &&
                    (((err > 11'sd0)
                      && (acc_reg < $signed({{2{cfg.accum_upper[15]}}, cfg.accum_upper})))
                  || ((err <= 11'sd0)
                      && (acc_reg > $signed({{2{cfg.accum_lower[15]}}, cfg.accum_lower}))));
        acc_int = integrate ? acc_reg + {{(18-SAMPLE_BITS-1){err[SAMPLE_BITS]}}, err} : acc_reg;

        prod_p  = {{(28-SAMPLE_BITS-1){err[SAMPLE_BITS]}}, err} * $signed({12'b0, cfg.prop_gain});
        prod_i  = {{17{acc_int[17]}}, acc_int} * $signed({19'b0, cfg.int_gain});
        sum     = $signed({{8{prod_p[27]}}, prod_p}) + $signed({prod_i[34], prod_i});
        sum_adj = sum + (sum[35] ? 36'(GAIN_DIVISOR - 1) : 36'sd0);
        quot    = sum_adj >>> GAIN_SHIFT;
        over    = quot[35] || (quot > $signed({20'b0, cfg.duty_limit}));
        pi_out  = over ? cfg.duty_limit : quot[15:0];

        acc_next    = acc_reg;
        sat_next    = sat_reg;
        held_next   = held_reg;
        duty_next   = duty_reg;
        sticky_next = sticky_eff;
        result      = '0;

        if (disconnect) begin
            acc_next  = '0;
            sat_next  = 1'b0;
            duty_next = '0;
            result.standby        = 1'b1;
            result.load_condition = COND_DISCONNECT;
        end else if (is_short) begin
            sticky_next = 1'b1;
            result.load_condition = COND_SHORT;
        end else begin
            if (big_err) begin
                acc_next  = acc_int;
                sat_next  = over;
                held_next = pi_out;
            end
            duty_next = held_next;
            result.pwm_on    = 1'b1;
            result.switch_on = 1'b1;
            result.load_condition = is_open ? COND_OPEN : COND_REGULATING;
        end

        result.duty          = duty_next;
        result.latched_fault = sticky_next;
        result.clamped       = sat_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg    <= '0;
            sat_reg    <= 1'b0;
            held_reg   <= '0;
            duty_reg   <= '0;
            sticky_reg <= 1'b0;
        end else if (step) begin
            acc_reg    <= acc_next;
            sat_reg    <= sat_next;
            held_reg   <= held_next;
            duty_reg   <= duty_next;
            sticky_reg <= sticky_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/load_pi_current_regulator_top.sv =====
// ----------------------------------------------------------------------------
// Load PI current regulator
// Top level: input register, regulator core and result register.
// ----------------------------------------------------------------------------
// The input channel (s_valid, s_ready) carries one transaction per control
// tick: a current sample with the enable, fault and sticky-clear flags.
// The result channel (m_valid, m_ready) returns one transaction per input
// transaction, in order, with the duty value and the status flags.
// An accepted transaction is held in the input register and its result is
// loaded into the output register once that register is free or being
// emptied; the output register then offers it on the result channel.
// One transaction per cycle is taken in a steady stream while the receiver
// takes every result; the PI multipliers and the next controller state are
// combinational between the two registers.
// While the receiver stalls, the pending result stays in the output
// register and one further transaction may wait in the input register;
// s_ready then falls until the result is taken.
// Configuration writes through cfg_we, cfg_addr and cfg_wdata take effect on
// the next edge; the user makes them only while the block is idle (no check).
// Reset clears the valid flags of both registers, the controller state and
// sets the configuration to its defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module load_pi_current_regulator_top (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [lpcr_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  wire logic [lpcr_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [9:0]                          s_sample,
    input  wire logic                                s_load_enable,
    input  wire logic                                s_fault,
    input  wire logic                                s_clear_sticky,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [15:0]                              m_duty,
    output logic                                     m_pwm_on,
    output logic                                     m_switch_on,
    output logic                                     m_standby,
    output logic [1:0]                               m_load_condition,
    output logic                                     m_latched_fault,
    output logic                                     m_clamped
);
    import lpcr_pkg::*;

    lpcr_cfg_t    cfg;
    lpcr_item_t   item_reg;
    logic         in_valid_reg;
    lpcr_result_t core_result;
    lpcr_result_t res_reg;
    logic         out_valid_reg;
    logic         advance;
    logic         s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    lpcr_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lpcr_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.sample       <= s_sample[SAMPLE_BITS-1:0];
            item_reg.load_enable  <= s_load_enable;
            item_reg.fault        <= s_fault;
            item_reg.clear_sticky <= s_clear_sticky;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= core_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_duty           = res_reg.duty;
    assign m_pwm_on         = res_reg.pwm_on;
    assign m_switch_on      = res_reg.switch_on;
    assign m_standby        = res_reg.standby;
    assign m_load_condition = res_reg.load_condition;
    assign m_latched_fault  = res_reg.latched_fault;
    assign m_clamped        = res_reg.clamped;

`ifndef SYNTHESIS
    a_disconnect_outputs: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_standby |-> m_duty == 16'd0 && !m_pwm_on && !m_switch_on
            && !m_clamped && m_load_condition == COND_DISCONNECT)
        else $error("Disconnect result with live outputs.");

    a_pwm_needs_switch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_pwm_on |-> m_switch_on
            && (m_load_condition == COND_OPEN || m_load_condition == COND_REGULATING))
        else $error("PWM enabled outside regulation.");

    a_short_latches: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_load_condition == COND_SHORT |-> m_latched_fault && !m_pwm_on)
        else $error("Short circuit result without latched fault.");

    a_stall_reason: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && out_valid_reg && !m_ready)
        else $error("Input stalled without a full pipeline.");
`endif

endmodule

`default_nettype wire

// ===== bench/lpcr_checker.sv =====
// ----------------------------------------------------------------------------
// Load PI current regulator result checker
// Watches the register write port and both channels of the regulator. It
// keeps its own copy of the settings and the controller state, predicts the
// result of every accepted tick and compares each returned result with the
// oldest prediction, field by field.
// ----------------------------------------------------------------------------
module lpcr_checker
    import lpcr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    input  logic                     s_valid,
    input  logic                     s_ready,
    input  logic [9:0]               s_sample,
    input  logic                     s_load_enable,
    input  logic                     s_fault,
    input  logic                     s_clear_sticky,
    input  logic                     m_valid,
    input  logic                     m_ready,
    input  logic [15:0]              m_duty,
    input  logic                     m_pwm_on,
    input  logic                     m_switch_on,
    input  logic                     m_standby,
    input  logic [1:0]               m_load_condition,
    input  logic                     m_latched_fault,
    input  logic                     m_clamped,
    output int                       fail_count,
    output int                       pending,
    output int                       results_seen,
    output int                       short_ticks,
    output int                       clamped_ticks
);
    timeunit 1ns;
    timeprecision 1ps;

    lpcr_cfg_t      settings;
    int             integral;
    bit             saturated;
    logic [15:0]    last_output;
    logic [15:0]    duty_now;
    bit             short_latched;
    lpcr_result_t   expected_results[$];

    function automatic lpcr_result_t regulate_tick(input lpcr_item_t tick);
        lpcr_result_t r;
        int           err;
        int           setpoint;
        int           level;
        int           upper;
        int           lower;
        longint       total;
        longint       quot;
        longint       pgain;
        longint       igain;
        longint       limit;
        r = '0;
        setpoint = settings.target_level;
        level = tick.sample;
        upper = settings.accum_upper;
        lower = settings.accum_lower;
        pgain = settings.prop_gain;
        igain = settings.int_gain;
        limit = settings.duty_limit;
        if (tick.clear_sticky) begin
            short_latched = 1'b0;
        end
        if (!tick.load_enable || tick.fault || short_latched) begin
            integral = 0;
            saturated = 1'b0;
            duty_now = '0;
            r.standby = 1'b1;
            r.load_condition = COND_DISCONNECT;
        end else if (tick.sample > settings.open_level && tick.sample >= settings.short_level) begin
            short_latched = 1'b1;
            r.load_condition = COND_SHORT;
        end else begin
            err = setpoint - level;
            r.load_condition = (tick.sample <= settings.open_level) ? COND_OPEN : COND_REGULATING;
            r.pwm_on = 1'b1;
            r.switch_on = 1'b1;
            if (err > 1 || err < -1) begin
                if (!saturated) begin
                    if (err > 0) begin
                        if (integral < upper) begin
                            integral += err;
                        end
                    end else if (integral > lower) begin
                        integral += err;
                    end
                end
                total = longint'(err) * pgain + longint'(integral) * igain;
                quot = total / GAIN_DIVISOR;
                if (quot > limit || quot < 0) begin
                    saturated = 1'b1;
                    last_output = settings.duty_limit;
                end else begin
                    saturated = 1'b0;
                    last_output = quot[15:0];
                end
            end
            duty_now = last_output;
        end
        r.duty = duty_now;
        r.latched_fault = short_latched;
        r.clamped = saturated;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge aclk) begin : monitor
        lpcr_item_t   tick;
        lpcr_result_t got;
        lpcr_result_t want;
        if (!aresetn) begin
            settings.target_level = '0;
            settings.prop_gain = 16'd1;
            settings.int_gain = 16'd1;
            settings.duty_limit = 16'hFFFF;
            settings.accum_upper = 16'sh7FFF;
            settings.accum_lower = 16'sh8000;
            settings.open_level = '0;
            settings.short_level = 10'd1023;
            integral = 0;
            saturated = 1'b0;
            last_output = '0;
            duty_now = '0;
            short_latched = 1'b0;
            expected_results.delete();
            fail_count = 0;
            pending = 0;
            results_seen = 0;
            short_ticks = 0;
            clamped_ticks = 0;
        end else begin
            if (m_valid && m_ready) begin
                got.duty = m_duty;
                got.pwm_on = m_pwm_on;
                got.switch_on = m_switch_on;
                got.standby = m_standby;
                got.load_condition = m_load_condition;
                got.latched_fault = m_latched_fault;
                got.clamped = m_clamped;
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result transaction with none expected, duty %0d",
                             $time, got.duty);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (want.load_condition == COND_SHORT) begin
                        short_ticks++;
                    end
                    if (want.clamped) begin
                        clamped_ticks++;
                    end
                    check_field("duty", want.duty, got.duty);
                    check_field("pwm_on", 16'(want.pwm_on), 16'(got.pwm_on));
                    check_field("switch_on", 16'(want.switch_on), 16'(got.switch_on));
                    check_field("standby", 16'(want.standby), 16'(got.standby));
                    check_field("load_condition", 16'(want.load_condition),
                                16'(got.load_condition));
                    check_field("latched_fault", 16'(want.latched_fault),
                                16'(got.latched_fault));
                    check_field("clamped", 16'(want.clamped), 16'(got.clamped));
                end
            end
            if (s_valid && s_ready) begin
                tick.sample = s_sample;
                tick.load_enable = s_load_enable;
                tick.fault = s_fault;
                tick.clear_sticky = s_clear_sticky;
                expected_results.push_back(regulate_tick(tick));
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_TARGET_LEVEL: settings.target_level = cfg_wdata[SAMPLE_BITS-1:0];
                    REG_PROP_GAIN:    settings.prop_gain = cfg_wdata;
                    REG_INT_GAIN:     settings.int_gain = cfg_wdata;
                    REG_DUTY_LIMIT:   settings.duty_limit = cfg_wdata;
                    REG_ACCUM_UPPER:  settings.accum_upper = cfg_wdata;
                    REG_ACCUM_LOWER:  settings.accum_lower = cfg_wdata;
                    REG_OPEN_LEVEL:   settings.open_level = cfg_wdata[SAMPLE_BITS-1:0];
                    REG_SHORT_LEVEL:  settings.short_level = cfg_wdata[SAMPLE_BITS-1:0];
                    default: ;
                endcase
            end
            pending = expected_results.size();
        end
    end

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// Load PI current regulator testbench
// Drives two short directed sequences and then phases of random control ticks
// through the regulator under several register settings and handshake idle
// profiles, including one long result stall. The checker beside the block
// predicts and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import lpcr_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_CYCLES    = 400;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_TICKS    = 166;
    localparam int PRESSURE_PHASE = 4;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0] cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [9:0]               s_sample = '0;
    logic                     s_load_enable = 1'b0;
    logic                     s_fault = 1'b0;
    logic                     s_clear_sticky = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [15:0]              m_duty;
    logic                     m_pwm_on;
    logic                     m_switch_on;
    logic                     m_standby;
    logic [1:0]               m_load_condition;
    logic                     m_latched_fault;
    logic                     m_clamped;

    int         fail_count;
    int         pending;
    int         results_seen;
    int         short_ticks;
    int         clamped_ticks;
    int         ticks_sent = 0;
    int         settings_loaded = 0;
    int         quiet_cycles = 0;
    int         s_idle_pct = 0;
    int         m_stall_pct = 0;
    bit         hold_req = 1'b0;
    lpcr_cfg_t  active;
    int         sender_idle[4] = '{0, 74, 0, 19};
    int         receiver_stall[4] = '{0, 0, 74, 19};

    always #2 aclk = ~aclk;

    load_pi_current_regulator_top u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_load_enable    (s_load_enable),
        .s_fault          (s_fault),
        .s_clear_sticky   (s_clear_sticky),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_duty           (m_duty),
        .m_pwm_on         (m_pwm_on),
        .m_switch_on      (m_switch_on),
        .m_standby        (m_standby),
        .m_load_condition (m_load_condition),
        .m_latched_fault  (m_latched_fault),
        .m_clamped        (m_clamped)
    );

    lpcr_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_sample         (s_sample),
        .s_load_enable    (s_load_enable),
        .s_fault          (s_fault),
        .s_clear_sticky   (s_clear_sticky),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_duty           (m_duty),
        .m_pwm_on         (m_pwm_on),
        .m_switch_on      (m_switch_on),
        .m_standby        (m_standby),
        .m_load_condition (m_load_condition),
        .m_latched_fault  (m_latched_fault),
        .m_clamped        (m_clamped),
        .fail_count       (fail_count),
        .pending          (pending),
        .results_seen     (results_seen),
        .short_ticks      (short_ticks),
        .clamped_ticks    (clamped_ticks)
    );

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Watchdog expired at %0t ns with %0d results outstanding.",
                         $time, pending);
                $display("status: fail");
                $finish;
            end
        end
    end

    always begin : receiver
        @(negedge aclk);
        if (hold_req) begin
            hold_req = 1'b0;
            m_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge aclk);
        end else begin
            m_ready <= ($urandom_range(99) >= m_stall_pct);
        end
    end

    function automatic lpcr_cfg_t make_settings(input int tgt, input int pg, input int ig,
                                                 input int dl, input int up, input int lo,
                                                 input int op, input int sh);
        lpcr_cfg_t c;
        c.target_level = 10'(tgt);
        c.prop_gain = 16'(pg);
        c.int_gain = 16'(ig);
        c.duty_limit = 16'(dl);
        c.accum_upper = 16'(up);
        c.accum_lower = 16'(lo);
        c.open_level = 10'(op);
        c.short_level = 10'(sh);
        return c;
    endfunction

    // Either end of the legal range or a value from the useful middle.
    function automatic int pick(input int lo, input int hi, input int mid_lo, input int mid_hi);
        case ($urandom_range(5))
            0: return lo;
            1: return hi;
            default: return mid_lo + int'($urandom_range(mid_hi - mid_lo));
        endcase
    endfunction

    task automatic put_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
    endtask

    task automatic load_settings(input lpcr_cfg_t c);
        put_reg(REG_TARGET_LEVEL, {6'd0, c.target_level});
        put_reg(REG_PROP_GAIN, c.prop_gain);
        put_reg(REG_INT_GAIN, c.int_gain);
        put_reg(REG_DUTY_LIMIT, c.duty_limit);
        put_reg(REG_ACCUM_UPPER, c.accum_upper);
        put_reg(REG_ACCUM_LOWER, c.accum_lower);
        put_reg(REG_OPEN_LEVEL, {6'd0, c.open_level});
        put_reg(REG_SHORT_LEVEL, {6'd0, c.short_level});
        cfg_we <= 1'b0;
        active = c;
        settings_loaded++;
    endtask

    task automatic send_tick(input logic [9:0] smp, input logic en, input logic flt,
                             input logic clr);
        while ($urandom_range(99) < s_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= smp;
        s_load_enable <= en;
        s_fault <= flt;
        s_clear_sticky <= clr;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
        @(negedge aclk);
    endtask

    // Mostly enabled ticks with samples aimed at the setpoint and the
    // thresholds; the rest are full random noise.
    task automatic send_random_tick();
        int   v;
        logic en;
        logic flt;
        logic clr;
        en = ($urandom_range(99) >= 6);
        flt = ($urandom_range(99) < 4);
        clr = ($urandom_range(99) < 10);
        case ($urandom_range(9))
            0, 1:    v = $urandom_range(1023);
            2, 3, 4: v = int'(active.target_level) + int'($urandom_range(80)) - 40;
            5:       v = int'(active.target_level) + int'($urandom_range(2)) - 1;
            6:       v = int'(active.open_level) + int'($urandom_range(6)) - 3;
            7:       v = int'(active.short_level) + int'($urandom_range(6)) - 3;
            default: begin
                v = $urandom_range(1023);
                en = 1'($urandom_range(1));
                flt = 1'($urandom_range(1));
                clr = 1'($urandom_range(1));
            end
        endcase
        if (v < 0) begin
            v = 0;
        end else if (v > 1023) begin
            v = 1023;
        end
        send_tick(10'(v), en, flt, clr);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        load_settings(make_settings(512, 256, 16, 1000, 2000, -2000, 20, 1000));
        send_tick(10'd512, 1'b0, 1'b0, 1'b0);
        send_tick(10'd300, 1'b1, 1'b1, 1'b0);
        send_tick(10'd300, 1'b1, 1'b0, 1'b0);
        send_tick(10'd511, 1'b1, 1'b0, 1'b0);
        send_tick(10'd512, 1'b1, 1'b0, 1'b0);
        send_tick(10'd513, 1'b1, 1'b0, 1'b0);
        send_tick(10'd700, 1'b1, 1'b0, 1'b0);
        send_tick(10'd100, 1'b1, 1'b0, 1'b0);
        send_tick(10'd0, 1'b1, 1'b0, 1'b0);
        send_tick(10'd20, 1'b1, 1'b0, 1'b0);
        send_tick(10'd21, 1'b1, 1'b0, 1'b0);
        send_tick(10'd999, 1'b1, 1'b0, 1'b0);
        send_tick(10'd1000, 1'b1, 1'b0, 1'b0);
        send_tick(10'd300, 1'b1, 1'b0, 1'b0);
        send_tick(10'd300, 1'b1, 1'b0, 1'b1);
        send_tick(10'd1023, 1'b1, 1'b1, 1'b1);
        send_tick(10'd1023, 1'b1, 1'b0, 1'b0);
        send_tick(10'd1023, 1'b0, 1'b0, 1'b1);
        send_tick(10'd400, 1'b1, 1'b1, 1'b1);
        drain();

        // Open and short bands overlap here, so open must win.
        load_settings(make_settings(300, 512, 64, 40000, 500, -500, 600, 500));
        send_tick(10'd550, 1'b1, 1'b0, 1'b0);
        send_tick(10'd600, 1'b1, 1'b0, 1'b0);
        send_tick(10'd601, 1'b1, 1'b0, 1'b0);
        send_tick(10'd450, 1'b1, 1'b0, 1'b1);
        send_tick(10'd200, 1'b1, 1'b0, 1'b0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                load_settings(make_settings(600, 300, 20, 65535, 32767, -32768, 0, 1023));
            end else if (phase == 1) begin
                load_settings(make_settings(1023, 65535, 65535, 0, -32768, 32767, 0, 0));
            end else begin
                load_settings(make_settings(pick(0, 1023, 100, 900),
                                            pick(0, 65535, 0, 2048),
                                            pick(0, 65535, 0, 512),
                                            pick(0, 65535, 100, 60000),
                                            pick(-32768, 32767, -2000, 20000),
                                            pick(-32768, 32767, -20000, 2000),
                                            pick(0, 1023, 0, 150),
                                            pick(0, 1023, 850, 1023)));
            end
            s_idle_pct = sender_idle[phase % 4];
            m_stall_pct = receiver_stall[phase % 4];
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (phase == PRESSURE_PHASE && n == 20) begin
                    hold_req <= 1'b1;
                end
                send_random_tick();
            end
            drain();
        end

        repeat (8) @(negedge aclk);
        $display("Sent %0d control ticks under %0d register settings and four idle profiles,",
                 ticks_sent, settings_loaded);
        $display("with %0d results checked, %0d short circuit and %0d clamped results.",
                 results_seen, short_ticks, clamped_ticks);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
